### src/inplace_box3x3_smoother_unit_macros.svh
// assertion helpers for the box smoother
`ifndef INPLACE_BOX3X3_SMOOTHER_UNIT_MACROS_SVH
`define INPLACE_BOX3X3_SMOOTHER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define IBS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define IBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IBS_ASSERT_IMPLY(label, ante, cons, msg)
`define IBS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### src/ibs_pkg.sv
package ibs_pkg;

  localparam int GRID_SIZE = 32;
  localparam int HEIGHT_W  = 16;

  // raw line buffer: two rows plus a little slack
  localparam int RAW_DEPTH = 2 * GRID_SIZE + 3;
  localparam int RAW_AW    = $clog2(RAW_DEPTH);
  localparam int CNT_W     = $clog2(RAW_DEPTH + 1);
  localparam int FIN_AW    = $clog2(GRID_SIZE);
  localparam int POS_W     = $clog2(GRID_SIZE);

  // sum of eight and of nine samples
  localparam int PSUM_W = HEIGHT_W + 3;
  localparam int SUM_W  = HEIGHT_W + 4;
  localparam int MAG_W  = SUM_W - 1;

  // divide by nine as multiply by ceil(2^22 / 9), exact below 2^21
  localparam int DIV_SHIFT = 22;
  localparam int DIV_MULT  = (2 ** DIV_SHIFT + 8) / 9;
  localparam int MULT_W    = DIV_SHIFT - 3;
  localparam int PROD_W    = MAG_W + MULT_W;

  typedef logic signed [HEIGHT_W-1:0] height_t;

endpackage

### src/ibs_if.sv
interface ibs_in_if import ibs_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height_in;

  modport source (output valid, output height_in, input ready);
  modport sink   (input valid, input height_in, output ready);
endinterface

interface ibs_out_if import ibs_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height_out;
  logic    run_last;
  logic    frame_last;

  modport source (output valid, output height_out, output run_last, output frame_last,
                  input ready);
  modport sink   (input valid, input height_out, input run_last, input frame_last,
                  output ready);
endinterface

### src/inplace_box3x3_smoother_unit.sv
// in-place 3x3 box smoother for a square height grid, GRID_SIZE cells a side
// in_ch: one signed 16-bit height per transaction, raster order, frames back to back
// out_ch: smoothed heights in raster order; run_last closes the results of one
//   input cell, frame_last marks the final cell of the grid
// interior cells take the mean of their 3x3 neighborhood, where the three cells
//   above and the one to the left are already smoothed; border cells pass as is
// a cell's result starts once the cell one row plus one below it is held, then
//   passes memory read, tap shift, partial sum and mean into the output register
// throughput: one transaction per cycle on each side while out_ch is ready, set
//   by the single read-modify-write loop through the mean unit (left neighbor
//   feedback); grids narrower than five cells wait on the row-above buffer and run slower
// the final cell of a frame releases the last GRID_SIZE+2 results as a burst at one per
//   cycle while out_ch is ready; the next frame keeps streaming into the raw line buffer
// when out_ch stalls the result pipeline freezes; inputs are still taken until
//   2*GRID_SIZE+3 cells wait unprocessed, then in_ch.ready drops
// reset (rst_n low, synchronous) clears positions, pointers and valid flags;
//   the line buffers are not cleared and need no clearing pass
module inplace_box3x3_smoother_unit import ibs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ibs_in_if.sink    in_ch,
  ibs_out_if.source out_ch
);

  `include "inplace_box3x3_smoother_unit_macros.svh"

  // per-cell flags carried down the pipeline
  typedef struct packed {
    logic first;
    logic border;
    logic run_last;
    logic frame_last;
  } cell_tag_t;

  // raw samples, written by the input side and read twice per cell
  height_t raw_mem [RAW_DEPTH];
  // final values of the last row, read back as the row above
  height_t fin_mem [GRID_SIZE];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAW_AW-1:0] wr_ptr_r, mid_ptr_r, lo_ptr_r;
  logic [RAW_AW-1:0] lo_addr;
  logic [FIN_AW-1:0] fin_rd_ptr_r, fin_wr_ptr_r;
  logic [POS_W-1:0]  row_r, col_r;

  height_t raw_mid_q_r, raw_lo_q_r, fin_q_r;

  logic      b_valid_r, c_valid_r, d_valid_r;
  cell_tag_t b_tag_r, c_tag_r, d_tag_r;

  height_t up_tap_r  [3];
  height_t mid_tap_r [2];
  height_t lo_tap_r  [3];

  logic signed [PSUM_W-1:0] psum_r;
  height_t                  d_raw_r;
  height_t                  last_q_r;

  logic    out_valid_r;
  height_t out_height_r;
  logic    out_run_last_r;
  logic    out_frame_last_r;

  logic             adv;
  logic             in_fire;
  logic             step;
  logic             d_fire;
  logic [1:0]       inflight;
  logic             interlock_ok;
  logic [CNT_W-1:0] need;
  cell_tag_t        tag;
  height_t          mean_val;
  height_t          q_val;

  // the whole result pipeline moves when the output register can take a result
  assign adv     = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign d_fire  = adv && d_valid_r;

  // keep every cell still to be read safe from being overwritten
  assign in_ch.ready = (cnt_r < CNT_W'(RAW_DEPTH));

  // cells in flight must not include the row-above cell being read back
  assign inflight     = 2'(b_valid_r) + 2'(c_valid_r) + 2'(d_valid_r);
  assign interlock_ok = (int'(inflight) <= GRID_SIZE - 2);

  // cells that must already sit in the buffer: up to one row plus one ahead,
  // fewer at the tail of the frame where the lower neighbors run out
  always_comb begin
    if (row_r == POS_W'(GRID_SIZE - 1)) begin
      need = CNT_W'(GRID_SIZE - 1) - CNT_W'(col_r);
    end else if (row_r == POS_W'(GRID_SIZE - 2) && col_r == POS_W'(GRID_SIZE - 1)) begin
      need = CNT_W'(GRID_SIZE);
    end else begin
      need = CNT_W'(GRID_SIZE + 1);
    end
  end

  assign step = adv && interlock_ok && (cnt_r > need);

  // result flags follow from the position alone
  always_comb begin
    tag.first      = (row_r == '0) && (col_r == '0);
    tag.border     = (row_r == '0) || (row_r == POS_W'(GRID_SIZE - 1)) ||
                     (col_r == '0) || (col_r == POS_W'(GRID_SIZE - 1));
    tag.frame_last = (row_r == POS_W'(GRID_SIZE - 1)) && (col_r == POS_W'(GRID_SIZE - 1));
    // the tail of the frame goes out as one run closed by the final cell
    tag.run_last   = !(((row_r == POS_W'(GRID_SIZE - 1)) &&
                        (col_r != POS_W'(GRID_SIZE - 1))) ||
                       ((row_r == POS_W'(GRID_SIZE - 2)) &&
                        (col_r >= POS_W'(GRID_SIZE - 2))));
  end

  // the first cell of a frame has no earlier read of its own sample, so the
  // row-below port, unused that early in the frame, fetches it instead
  assign lo_addr = !tag.first ? lo_ptr_r :
                   (mid_ptr_r == '0) ? RAW_AW'(RAW_DEPTH - 1) : mid_ptr_r - 1'b1;

  assign cnt_nxt = cnt_r + CNT_W'(in_fire) - CNT_W'(step);

  // raw line buffer: one write port, two read ports
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_mem[wr_ptr_r] <= in_ch.height_in;
    end
    if (step) begin
      raw_mid_q_r <= raw_mem[mid_ptr_r];
      raw_lo_q_r  <= raw_mem[lo_addr];
    end
  end

  // final-value line buffer: written back as each cell completes
  always_ff @(posedge clk) begin
    if (d_fire) begin
      fin_mem[fin_wr_ptr_r] <= q_val;
    end
    if (step) begin
      fin_q_r <= fin_mem[fin_rd_ptr_r];
    end
  end

  // pointers, occupancy and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      wr_ptr_r     <= '0;
      mid_ptr_r    <= RAW_AW'(1);
      lo_ptr_r     <= RAW_AW'(GRID_SIZE + 1);
      fin_rd_ptr_r <= FIN_AW'(1);
      fin_wr_ptr_r <= '0;
      row_r        <= '0;
      col_r        <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        wr_ptr_r <= (wr_ptr_r == RAW_AW'(RAW_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (step) begin
        mid_ptr_r    <= (mid_ptr_r == RAW_AW'(RAW_DEPTH - 1)) ? '0 : mid_ptr_r + 1'b1;
        lo_ptr_r     <= (lo_ptr_r == RAW_AW'(RAW_DEPTH - 1)) ? '0 : lo_ptr_r + 1'b1;
        fin_rd_ptr_r <= (fin_rd_ptr_r == FIN_AW'(GRID_SIZE - 1)) ? '0 : fin_rd_ptr_r + 1'b1;
        if (col_r == POS_W'(GRID_SIZE - 1)) begin
          col_r <= '0;
          row_r <= (row_r == POS_W'(GRID_SIZE - 1)) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (d_fire) begin
        fin_wr_ptr_r <= (fin_wr_ptr_r == FIN_AW'(GRID_SIZE - 1)) ? '0 : fin_wr_ptr_r + 1'b1;
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r   <= step;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  // window taps, partial sum and result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag_r <= tag;
      c_tag_r <= b_tag_r;
      d_tag_r <= c_tag_r;
      // taps slide one cell: row above, own row, row below
      if (b_valid_r) begin
        up_tap_r[0]  <= up_tap_r[1];
        up_tap_r[1]  <= up_tap_r[2];
        up_tap_r[2]  <= fin_q_r;
        mid_tap_r[0] <= b_tag_r.first ? raw_lo_q_r : mid_tap_r[1];
        mid_tap_r[1] <= raw_mid_q_r;
        lo_tap_r[0]  <= lo_tap_r[1];
        lo_tap_r[1]  <= lo_tap_r[2];
        lo_tap_r[2]  <= raw_lo_q_r;
      end
      // everything but the left neighbor, which is still being computed
      psum_r  <= PSUM_W'(up_tap_r[0]) + PSUM_W'(up_tap_r[1]) + PSUM_W'(up_tap_r[2]) +
                 PSUM_W'(mid_tap_r[0]) + PSUM_W'(mid_tap_r[1]) +
                 PSUM_W'(lo_tap_r[0]) + PSUM_W'(lo_tap_r[1]) + PSUM_W'(lo_tap_r[2]);
      d_raw_r <= mid_tap_r[0];
    end
    if (d_fire) begin
      last_q_r         <= q_val;
      out_height_r     <= q_val;
      out_run_last_r   <= d_tag_r.run_last;
      out_frame_last_r <= d_tag_r.frame_last;
    end
  end

  // left neighbor closes the loop through the mean unit
  ibs_mean9 u_mean9 (
    .psum     (psum_r),
    .left_val (last_q_r),
    .mean     (mean_val)
  );

  assign q_val = d_tag_r.border ? d_raw_r : mean_val;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.height_out = out_height_r;
  assign out_ch.run_last   = out_run_last_r;
  assign out_ch.frame_last = out_frame_last_r;

  // checks
  `IBS_ASSERT_IMPLY(a_occupancy_bound, 1'b1, cnt_r <= CNT_W'(RAW_DEPTH), "raw buffer overrun")
  `IBS_ASSERT_IMPLY(a_frame_last_ends_run, out_ch.valid && out_ch.frame_last, out_ch.run_last, "frame end not closing a run")
  `IBS_ASSERT_NEXT(a_frame_wrap, step && tag.frame_last, row_r == '0 && col_r == '0, "position did not wrap at frame end")

endmodule

### src/ibs_mean9.sv
module ibs_mean9 import ibs_pkg::*; (
  input  logic signed [PSUM_W-1:0] psum,
  input  height_t                  left_val,
  output height_t                  mean
);

  logic signed [SUM_W-1:0] sum;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [HEIGHT_W-1:0]     quo;
  logic [HEIGHT_W:0]       quo_ext;
  logic [HEIGHT_W:0]       quo_neg;

  assign sum = SUM_W'(psum) + SUM_W'(left_val);

  // positive sums round half up via +4, negative sums truncate toward zero
  always_comb begin
    if (sum[SUM_W-1]) begin
      mag = MAG_W'(-sum);
    end else begin
      mag = MAG_W'(sum + SUM_W'(4));
    end
  end

  assign prod    = {{MULT_W{1'b0}}, mag} * {{MAG_W{1'b0}}, MULT_W'(DIV_MULT)};
  assign quo     = prod[DIV_SHIFT +: HEIGHT_W];
  assign quo_ext = {1'b0, quo};
  assign quo_neg = -quo_ext;

  assign mean = sum[SUM_W-1] ? height_t'(quo_neg[HEIGHT_W-1:0]) : height_t'(quo);

endmodule
